/* src/tdts_pkg.sv */
package tdts_pkg;

  // One input item and one result item
  typedef struct packed {
    logic        opcode;
    logic [3:0]  slot_index;
    logic [15:0] slot_priority;
    logic [15:0] slot_counter;
  } in_item_t;

  typedef struct packed {
    logic [3:0] running_slot;
    logic       switched;
    logic       refilled;
  } out_item_t;

  // Item opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic [0:0] CFG_POLICY_SELECT = 1'd0;
  localparam logic [0:0] CFG_REFILL_SEED   = 1'd1;

  // Policy codes
  localparam logic POLICY_SHORTEST = 1'b0;
  localparam logic POLICY_PRIORITY = 1'b1;

  // Refill generator
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;
  localparam logic [15:0] SEED_RESET = 16'h0001;

  // Datapath actions, one per control word
  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_ACCEPT,
    ACT_WRITE_SLOT,
    ACT_READ_CUR,
    ACT_DEC_CUR,
    ACT_SCAN_INIT,
    ACT_SCAN_STEP,
    ACT_COMMIT,
    ACT_REFILL_INIT,
    ACT_REFILL_STEP,
    ACT_EMIT
  } act_e;

  // Jump conditions
  typedef enum logic [3:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_INPUT,
    CND_IS_TICK,
    CND_CUR_IDLE,
    CND_RD_ZERO,
    CND_DEC_NONZERO,
    CND_SCAN_MORE,
    CND_FOUND,
    CND_REFILL_MORE,
    CND_OUT_BUSY
  } cond_e;

  localparam int PC_W = 4;

  // Program step addresses
  localparam logic [PC_W-1:0] ST_WAIT        = 4'd0;
  localparam logic [PC_W-1:0] ST_DECODE      = 4'd1;
  localparam logic [PC_W-1:0] ST_WRITE       = 4'd2;
  localparam logic [PC_W-1:0] ST_TICK        = 4'd3;
  localparam logic [PC_W-1:0] ST_CHECK       = 4'd4;
  localparam logic [PC_W-1:0] ST_DEC         = 4'd5;
  localparam logic [PC_W-1:0] ST_SCAN        = 4'd6;
  localparam logic [PC_W-1:0] ST_SCAN_LOOP   = 4'd7;
  localparam logic [PC_W-1:0] ST_COMMIT      = 4'd8;
  localparam logic [PC_W-1:0] ST_REFILL      = 4'd9;
  localparam logic [PC_W-1:0] ST_REFILL_LOOP = 4'd10;
  localparam logic [PC_W-1:0] ST_RESCAN      = 4'd11;
  localparam logic [PC_W-1:0] ST_OUT_WAIT    = 4'd12;
  localparam logic [PC_W-1:0] ST_EMIT        = 4'd13;

  typedef struct packed {
    act_e            act;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    act_e act;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic is_tick;
    logic cur_idle;
    logic rd_zero;
    logic dec_nonzero;
    logic scan_more;
    logic found;
    logic refill_more;
    logic out_busy;
  } stat_t;

  // Control store: jump to target when the condition holds, else next step
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      ST_WAIT:        w = '{ACT_ACCEPT,      CND_NO_INPUT,    ST_WAIT};
      ST_DECODE:      w = '{ACT_NOP,         CND_IS_TICK,     ST_TICK};
      ST_WRITE:       w = '{ACT_WRITE_SLOT,  CND_ALWAYS,      ST_OUT_WAIT};
      ST_TICK:        w = '{ACT_READ_CUR,    CND_CUR_IDLE,    ST_SCAN};
      ST_CHECK:       w = '{ACT_NOP,         CND_RD_ZERO,     ST_SCAN};
      ST_DEC:         w = '{ACT_DEC_CUR,     CND_DEC_NONZERO, ST_OUT_WAIT};
      ST_SCAN:        w = '{ACT_SCAN_INIT,   CND_NEVER,       ST_WAIT};
      ST_SCAN_LOOP:   w = '{ACT_SCAN_STEP,   CND_SCAN_MORE,   ST_SCAN_LOOP};
      ST_COMMIT:      w = '{ACT_COMMIT,      CND_FOUND,       ST_OUT_WAIT};
      ST_REFILL:      w = '{ACT_REFILL_INIT, CND_NEVER,       ST_WAIT};
      ST_REFILL_LOOP: w = '{ACT_REFILL_STEP, CND_REFILL_MORE, ST_REFILL_LOOP};
      ST_RESCAN:      w = '{ACT_NOP,         CND_ALWAYS,      ST_SCAN};
      ST_OUT_WAIT:    w = '{ACT_NOP,         CND_OUT_BUSY,    ST_OUT_WAIT};
      ST_EMIT:        w = '{ACT_EMIT,        CND_ALWAYS,      ST_WAIT};
      default:        w = '{ACT_NOP,         CND_ALWAYS,      ST_WAIT};
    endcase
    return w;
  endfunction

  // One step of the Galois refill generator
  function automatic logic [15:0] lfsr_next(input logic [15:0] s);
    logic [15:0] n;
    n = {1'b0, s[15:1]};
    if (s[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

endpackage

/* src/tdts_ram.sv */
module tdts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/tdts_useq.sv */
module tdts_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tdts_pkg::stat_t stat_i,
  output tdts_pkg::ctrl_t ctrl_o
);
  import tdts_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            take;

  assign uw         = ucode(pc_q);
  assign ctrl_o.act = uw.act;

  // Condition select
  always_comb begin
    unique case (uw.cond)
      CND_NEVER:       take = 1'b0;
      CND_ALWAYS:      take = 1'b1;
      CND_NO_INPUT:    take = !stat_i.in_valid;
      CND_IS_TICK:     take = stat_i.is_tick;
      CND_CUR_IDLE:    take = stat_i.cur_idle;
      CND_RD_ZERO:     take = stat_i.rd_zero;
      CND_DEC_NONZERO: take = stat_i.dec_nonzero;
      CND_SCAN_MORE:   take = stat_i.scan_more;
      CND_FOUND:       take = stat_i.found;
      CND_REFILL_MORE: take = stat_i.refill_more;
      CND_OUT_BUSY:    take = stat_i.out_busy;
      default:         take = 1'b0;
    endcase
    pc_d = take ? uw.target : pc_q + 1'b1;
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* src/tdts_dpath.sv */
module tdts_dpath #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tdts_pkg::ctrl_t     ctrl_i,
  output tdts_pkg::stat_t     stat_o,
  input  logic                policy_i,
  input  logic                seed_we_i,
  input  logic [15:0]         seed_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tdts_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tdts_pkg::out_item_t out_item_o
);
  import tdts_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);
  localparam logic [SW-1:0] LAST = SW'(NUM_SLOTS - 1);

  in_item_t        item_q;
  logic [SW-1:0]   cur_q, prev_q, ridx_q, best_q;
  logic [15:0]     best_cnt_q, best_pri_q, lfsr_q;
  logic            found_q, refill_q;
  logic            cvld_q [NUM_SLOTS];
  logic            pvld_q [NUM_SLOTS];
  logic            rd_cvld_q, rd_pvld_q;
  logic            out_valid_q;
  out_item_t       out_q;

  logic            accept;
  logic            slot_ok;
  logic [SW-1:0]   raddr;
  logic [SW-1:0]   cnt_waddr;
  logic [15:0]     cnt_wdata, cnt_rd, pri_rd, c_eff, p_eff;
  logic            cnt_we, pri_we;
  logic            better, take;

  // Tables
  tdts_ram #(.WIDTH(16), .DEPTH(NUM_SLOTS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (raddr),
    .rdata_o (cnt_rd)
  );

  tdts_ram #(.WIDTH(16), .DEPTH(NUM_SLOTS)) u_pri_ram (
    .clk_i   (clk_i),
    .we_i    (pri_we),
    .waddr_i (SW'(item_q.slot_index)),
    .wdata_i (item_q.slot_priority),
    .raddr_i (raddr),
    .rdata_o (pri_rd)
  );

  // Entries never written read as zero
  assign c_eff = rd_cvld_q ? cnt_rd : 16'd0;
  assign p_eff = rd_pvld_q ? pri_rd : 16'd0;

  assign accept     = (ctrl_i.act == ACT_ACCEPT) && in_valid_i;
  assign in_ready_o = (ctrl_i.act == ACT_ACCEPT);
  assign slot_ok    = (item_q.slot_index != 4'd0) && (int'(item_q.slot_index) < NUM_SLOTS);

  // Write port and read address selection
  always_comb begin
    pri_we    = (ctrl_i.act == ACT_WRITE_SLOT) && slot_ok;
    cnt_we    = 1'b0;
    cnt_waddr = SW'(item_q.slot_index);
    cnt_wdata = item_q.slot_counter;
    raddr     = cur_q;
    case (ctrl_i.act)
      ACT_WRITE_SLOT: cnt_we = slot_ok;
      ACT_DEC_CUR: begin
        cnt_we    = 1'b1;
        cnt_waddr = cur_q;
        cnt_wdata = c_eff - 16'd1;
      end
      ACT_REFILL_STEP: begin
        cnt_we    = 1'b1;
        cnt_waddr = ridx_q;
        cnt_wdata = lfsr_next(lfsr_q);
      end
      ACT_SCAN_INIT: raddr = '0;
      ACT_SCAN_STEP: raddr = (ridx_q == LAST) ? '0 : ridx_q + 1'b1;
      default: ;
    endcase
  end

  // Selection compare for the slot whose data is on the read port
  assign better = (policy_i == POLICY_PRIORITY) ? (p_eff >= best_pri_q)
                                                : (c_eff < best_cnt_q);
  assign take   = (c_eff != 16'd0) && (!found_q || better);

  // Status back to the sequencer
  assign stat_o.in_valid    = in_valid_i;
  assign stat_o.is_tick     = (item_q.opcode == OP_TICK);
  assign stat_o.cur_idle    = (cur_q == '0);
  assign stat_o.rd_zero     = (c_eff == 16'd0);
  assign stat_o.dec_nonzero = (c_eff != 16'd1);
  assign stat_o.scan_more   = (ridx_q != LAST);
  assign stat_o.found       = found_q;
  assign stat_o.refill_more = (ridx_q != LAST);
  assign stat_o.out_busy    = out_valid_q && !out_ready_i;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      lfsr_q      <= SEED_RESET;
      found_q     <= 1'b0;
      refill_q    <= 1'b0;
      rd_cvld_q   <= 1'b0;
      rd_pvld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        cvld_q[i] <= 1'b0;
        pvld_q[i] <= 1'b0;
      end
    end else begin
      rd_cvld_q <= cvld_q[raddr];
      rd_pvld_q <= pvld_q[raddr];
      if (cnt_we) begin
        cvld_q[cnt_waddr] <= 1'b1;
      end
      if (pri_we) begin
        pvld_q[SW'(item_q.slot_index)] <= 1'b1;
      end
      if (seed_we_i) begin
        lfsr_q <= (seed_i == 16'd0) ? SEED_RESET : seed_i;
      end else if (ctrl_i.act == ACT_REFILL_STEP) begin
        lfsr_q <= lfsr_next(lfsr_q);
      end
      if (accept) begin
        refill_q <= 1'b0;
      end else if (ctrl_i.act == ACT_REFILL_INIT) begin
        refill_q <= 1'b1;
      end
      if (ctrl_i.act == ACT_SCAN_INIT) begin
        found_q <= 1'b0;
      end else if (ctrl_i.act == ACT_SCAN_STEP && c_eff != 16'd0) begin
        found_q <= 1'b1;
      end
      if (ctrl_i.act == ACT_COMMIT && found_q) begin
        cur_q <= best_q;
      end
      if (ctrl_i.act == ACT_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
      prev_q <= cur_q;
    end
    case (ctrl_i.act)
      ACT_SCAN_INIT:   ridx_q <= '0;
      ACT_REFILL_INIT: ridx_q <= SW'(1);
      ACT_SCAN_STEP, ACT_REFILL_STEP: ridx_q <= ridx_q + 1'b1;
      default: ;
    endcase
    if (ctrl_i.act == ACT_SCAN_STEP && take) begin
      best_q     <= ridx_q;
      best_cnt_q <= c_eff;
      best_pri_q <= p_eff;
    end
    if (ctrl_i.act == ACT_EMIT) begin
      out_q.running_slot <= 4'(cur_q);
      out_q.switched     <= (cur_q != prev_q);
      out_q.refilled     <= refill_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // After a refill every slot but idle holds a nonzero count
  a_refill_finds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.act == ACT_COMMIT && refill_q) |-> found_q)
    else $error("scan after refill found no slot");

  // The idle slot never gets a counter
  a_idle_never_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cvld_q[0])
    else $error("idle slot counter was written");

  // A picked slot must hold a nonzero count at the time of the pick
  a_pick_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.act == ACT_SCAN_STEP && take) |-> (c_eff != 16'd0))
    else $error("scan picked an empty slot");

endmodule

/* src/tick_driven_task_scheduler.sv */
// Tick-driven task scheduler over NUM_SLOTS task slots; slot 0 is the idle slot.
// Input channel (in_valid_i/in_ready_o, in_item_i): a write item loads one
// slot's priority and counter; a tick item decrements the running slot and
// reschedules when it runs out, or at once when idle is running.
// Output channel (out_valid_o/out_ready_i, out_item_o): exactly one result item
// per input item, in order: running slot, switched flag, refilled flag.
// Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): always
// ready; index 0 sets the policy, index 1 sets and reloads the refill seed.
// Sequencing: a small microcoded sequencer steps through one item at a time.
// A tick that rescans runs the scan loop over every slot; one that also
// refills writes slots 1 and up from the refill generator and then scans
// again. The scan loop reads one slot per cycle from the table memories.
// The next item can be accepted in the cycle after the result is loaded.
// Reset: all slots empty, idle running, refill generator at seed 1.
// A stalled receiver holds the result register; the sequencer waits before
// loading the next result and meanwhile stops taking new items.
module tick_driven_task_scheduler #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tdts_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tdts_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [0:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import tdts_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  policy_q;
  logic  seed_we;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  assign seed_we     = cfg_valid_i && (cfg_index_i == CFG_REFILL_SEED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_SHORTEST;
    end else if (cfg_valid_i && cfg_index_i == CFG_POLICY_SELECT) begin
      policy_q <= cfg_data_i[0];
    end
  end

  tdts_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  tdts_dpath #(.NUM_SLOTS(NUM_SLOTS)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .policy_i    (policy_q),
    .seed_we_i   (seed_we),
    .seed_i      (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* dv/tb_tick_driven_task_scheduler.sv */
module tb_tick_driven_task_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import tdts_pkg::*;

  localparam int SLOTS      = 16;
  localparam int STALL_MAX  = 4000;
  localparam int DRAIN_WAIT = 80;

  typedef struct packed {
    logic [0:0]  idx;
    logic [15:0] data;
  } cfg_wr_t;

  // DUT ports
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i  = '0;

  // Stimulus queues and driver state
  in_item_t  task_item_q[$];
  cfg_wr_t   cfg_wr_q[$];
  bit        in_took   = 1'b0;
  bit        cfg_took  = 1'b0;
  bit        no_idle   = 1'b0;
  int        in_gap    = 0;
  int        out_stall = 0;
  int        gen_count = 0;
  int        err_cnt   = 0;
  int        quiet_cycles = 0;

  // Scheduler shadow state
  logic [15:0] slot_cnt [SLOTS];
  logic [15:0] slot_pri [SLOTS];
  logic [3:0]  run_slot;
  logic [15:0] refill_gen;
  logic        sched_policy;
  out_item_t   sched_expect_q[$];

  tick_driven_task_scheduler #(
    .NUM_SLOTS(SLOTS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 60);
  endfunction

  // Choose among slots with a nonzero counter per the active policy
  function automatic bit choose_slot(output logic [3:0] pick);
    bit          found;
    logic [15:0] best_cnt;
    logic [15:0] best_pri;
    int          i;
    found    = 1'b0;
    pick     = '0;
    best_cnt = '0;
    best_pri = '0;
    for (i = 0; i < SLOTS; i++) begin
      if (slot_cnt[i] != 16'd0) begin
        if (sched_policy == POLICY_SHORTEST) begin
          if (!found || slot_cnt[i] < best_cnt) begin
            pick     = i[3:0];
            best_cnt = slot_cnt[i];
          end
        end else if (!found || slot_pri[i] >= best_pri) begin
          pick     = i[3:0];
          best_pri = slot_pri[i];
        end
        found = 1'b1;
      end
    end
    return found;
  endfunction

  // Pick the next slot; refill slots 1 and up when all are exhausted
  function automatic bit reschedule();
    logic [3:0] pick;
    int         i;
    if (choose_slot(pick)) begin
      run_slot = pick;
      return 1'b0;
    end
    for (i = 1; i < SLOTS; i++) begin
      refill_gen  = refill_gen[0] ? ({1'b0, refill_gen[15:1]} ^ LFSR_TAPS)
                                  : {1'b0, refill_gen[15:1]};
      slot_cnt[i] = refill_gen;
    end
    if (choose_slot(pick)) begin
      run_slot = pick;
    end
    return 1'b1;
  endfunction

  // Expected result of one accepted item
  function automatic void predict_schedule(input in_item_t it);
    logic [3:0] prev;
    bit         refl;
    out_item_t  res;
    prev = run_slot;
    refl = 1'b0;
    if (it.opcode == OP_WRITE) begin
      if (it.slot_index != 4'd0) begin
        slot_pri[it.slot_index] = it.slot_priority;
        slot_cnt[it.slot_index] = it.slot_counter;
      end
    end else if (run_slot == 4'd0 || slot_cnt[run_slot] == 16'd0) begin
      refl = reschedule();
    end else begin
      slot_cnt[run_slot] = slot_cnt[run_slot] - 16'd1;
      if (slot_cnt[run_slot] == 16'd0) begin
        refl = reschedule();
      end
    end
    res.running_slot = run_slot;
    res.switched     = (run_slot != prev);
    res.refilled     = refl;
    sched_expect_q.push_back(res);
  endfunction

  // Input driver
  always @(negedge clk_i) begin
    if (in_valid_i && !in_took) begin
      in_valid_i <= 1'b1;
    end else if (in_gap > 0) begin
      in_valid_i <= 1'b0;
      in_gap--;
    end else if (task_item_q.size() > 0) begin
      in_valid_i <= 1'b1;
      in_item_i  <= task_item_q.pop_front();
      in_gap = pick_gap();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Result back-pressure
  always @(negedge clk_i) begin
    if (out_stall > 0) begin
      out_ready_i <= 1'b0;
      out_stall--;
    end else begin
      out_ready_i <= 1'b1;
      if (!no_idle && $urandom_range(0, 99) < 25) begin
        out_stall = pick_gap();
      end
    end
  end

  // Register write driver
  always @(negedge clk_i) begin
    if (cfg_valid_i && !cfg_took) begin
      cfg_valid_i <= 1'b1;
    end else if (cfg_wr_q.size() > 0) begin
      cfg_valid_i <= 1'b1;
      {cfg_index_i, cfg_data_i} <= cfg_wr_q.pop_front();
    end else begin
      cfg_valid_i <= 1'b0;
    end
  end

  // Monitor: apply accepted writes and items, check results
  always @(posedge clk_i) begin
    out_item_t exp_res;
    in_took  <= in_valid_i && in_ready_o;
    cfg_took <= cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_POLICY_SELECT) begin
          sched_policy = cfg_data_i[0];
        end else if (cfg_index_i == CFG_REFILL_SEED) begin
          refill_gen = (cfg_data_i == 16'd0) ? SEED_RESET : cfg_data_i;
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_schedule(in_item_i);
      end
      if (out_valid_o === 1'b1 && out_ready_i) begin
        if (sched_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got slot %0d sw %0b rf %0b",
                   $time, out_item_o.running_slot, out_item_o.switched,
                   out_item_o.refilled);
          err_cnt++;
        end else begin
          exp_res = sched_expect_q.pop_front();
          if (out_item_o.running_slot !== exp_res.running_slot) begin
            $display("%0t: running_slot expected %0d got %0d", $time,
                     exp_res.running_slot, out_item_o.running_slot);
            err_cnt++;
          end
          if (out_item_o.switched !== exp_res.switched) begin
            $display("%0t: switched expected %0b got %0b", $time,
                     exp_res.switched, out_item_o.switched);
            err_cnt++;
          end
          if (out_item_o.refilled !== exp_res.refilled) begin
            $display("%0t: refilled expected %0b got %0b", $time,
                     exp_res.refilled, out_item_o.refilled);
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: no handshake for too long while work is outstanding
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o === 1'b1 && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else if (task_item_q.size() > 0 || in_valid_i || sched_expect_q.size() > 0 ||
                 cfg_valid_i || cfg_wr_q.size() > 0) begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_MAX) begin
        $display("tick_driven_task_scheduler test failed");
        $finish;
      end
    end
  end

  task automatic queue_item(input logic op, input logic [3:0] idx,
                            input logic [15:0] pri, input logic [15:0] cnt);
    in_item_t it;
    it.opcode        = op;
    it.slot_index    = idx;
    it.slot_priority = pri;
    it.slot_counter  = cnt;
    task_item_q.push_back(it);
    gen_count++;
  endtask

  // Block until every item is accepted and every result is back
  task automatic wait_idle();
    while (task_item_q.size() > 0 || in_valid_i || sched_expect_q.size() > 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] data);
    cfg_wr_t w;
    w.idx  = idx;
    w.data = data;
    cfg_wr_q.push_back(w);
    @(posedge clk_i);
    while (cfg_wr_q.size() > 0 || cfg_valid_i) begin
      @(posedge clk_i);
    end
  endtask

  function automatic logic [15:0] rand_prio();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) begin
      return 16'h0000;
    end else if (r == 1) begin
      return 16'hFFFF;
    end else if (r == 2) begin
      return 16'($urandom_range(0, 3));
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // Main sequence
  initial begin
    int p;
    int k;
    int r;
    int n;
    int base;
    int start;
    int seed_sel;
    for (k = 0; k < SLOTS; k++) begin
      slot_cnt[k] = '0;
      slot_pri[k] = '0;
    end
    run_slot     = '0;
    refill_gen   = SEED_RESET;
    sched_policy = POLICY_SHORTEST;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: refill from idle, write to idle slot, field extremes
    queue_item(OP_TICK, 4'd0, 16'h0000, 16'h0000);
    queue_item(OP_WRITE, 4'd0, 16'hFFFF, 16'hFFFF);
    queue_item(OP_WRITE, 4'd15, 16'hFFFF, 16'h0001);
    queue_item(OP_WRITE, 4'd1, 16'h0000, 16'hFFFF);
    queue_item(OP_TICK, 4'd0, 16'h0000, 16'h0000);
    queue_item(OP_TICK, 4'd0, 16'h0000, 16'h0000);
    wait_idle();
    // Running slot's counter cleared by a write, then a tick
    queue_item(OP_WRITE, run_slot, 16'h1234, 16'h0000);
    queue_item(OP_TICK, 4'd0, 16'h0000, 16'h0000);
    wait_idle();

    // Priority policy, zero seed, ties at equal priority
    write_reg(CFG_POLICY_SELECT, {15'd0, POLICY_PRIORITY});
    write_reg(CFG_REFILL_SEED, 16'h0000);
    queue_item(OP_WRITE, 4'd3, 16'h0007, 16'h0002);
    queue_item(OP_WRITE, 4'd9, 16'h0007, 16'h0002);
    queue_item(OP_WRITE, 4'd12, 16'hFFFF, 16'h0000);
    queue_item(OP_WRITE, 4'd15, 16'h0006, 16'h0001);
    queue_item(OP_TICK, 4'd0, 16'h0000, 16'h0000);
    queue_item(OP_TICK, 4'd0, 16'h0000, 16'h0000);
    queue_item(OP_TICK, 4'd0, 16'h0000, 16'h0000);
    wait_idle();

    // Shortest policy, top seed, ties at equal counters
    write_reg(CFG_POLICY_SELECT, {15'd0, POLICY_SHORTEST});
    write_reg(CFG_REFILL_SEED, 16'hFFFF);
    queue_item(OP_WRITE, 4'd6, 16'h0000, 16'h0001);
    queue_item(OP_WRITE, 4'd2, 16'h0000, 16'h0001);
    queue_item(OP_TICK, 4'd0, 16'h0000, 16'h0000);
    queue_item(OP_TICK, 4'd0, 16'h0000, 16'h0000);
    queue_item(OP_TICK, 4'd0, 16'h0000, 16'h0000);
    wait_idle();

    // Random phases, each with its own register setting
    for (p = 0; p < 12; p++) begin
      wait_idle();
      no_idle = (p % 4 == 3);
      write_reg(CFG_POLICY_SELECT, {15'd0, 1'($urandom_range(0, 1))});
      seed_sel = $urandom_range(0, 4);
      if (seed_sel == 0) begin
        write_reg(CFG_REFILL_SEED, 16'h0000);
      end else if (seed_sel == 1) begin
        write_reg(CFG_REFILL_SEED, 16'h0001);
      end else if (seed_sel == 2) begin
        write_reg(CFG_REFILL_SEED, 16'hFFFF);
      end else begin
        write_reg(CFG_REFILL_SEED, 16'($urandom_range(0, 65535)));
      end
      start = gen_count;
      while (gen_count - start < 150) begin
        r = $urandom_range(0, 99);
        if (r < 25) begin
          // Clear the table, keeping a few short jobs, then tick
          base = $urandom_range(0, 14);
          for (k = 0; k < 15; k++) begin
            queue_item(OP_WRITE, 4'(((base + k) % 15) + 1), rand_prio(),
                       ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 3)) : 16'd0);
          end
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++) begin
            queue_item(OP_TICK, 4'($urandom_range(0, 15)), 16'h0000, 16'h0000);
          end
        end else if (r < 65) begin
          // Load a few short jobs and run them down
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++) begin
            queue_item(OP_WRITE, 4'($urandom_range(1, 15)), rand_prio(),
                       16'($urandom_range(1, 4)));
          end
          n = $urandom_range(2, 10);
          for (k = 0; k < n; k++) begin
            queue_item(OP_TICK, 4'd0, 16'h0000, 16'h0000);
          end
        end else if (r < 80) begin
          // Zero a random slot's counter, then tick
          queue_item(OP_WRITE, 4'($urandom_range(0, 15)), rand_prio(), 16'd0);
          queue_item(OP_TICK, 4'd0, 16'h0000, 16'h0000);
        end else begin
          // Noise over the full field ranges
          queue_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        end
      end
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tick_driven_task_scheduler test passed");
    end else begin
      $display("tick_driven_task_scheduler test failed");
    end
    $finish;
  end

endmodule

/* tick_driven_task_scheduler.f */
src/tdts_pkg.sv
src/tdts_ram.sv
src/tdts_useq.sv
src/tdts_dpath.sv
src/tick_driven_task_scheduler.sv
dv/tb_tick_driven_task_scheduler.sv
